[hw/rtl/ics_pkg.sv]
// Shared constants and types for the streaming Internet checksum block.
package ics_pkg;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 3;
   localparam int WORD_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int LANES_DEF = 4;

   localparam logic [WORD_W-1:0] WORD_MASK = 16'hffff;
   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

   typedef struct packed {
      logic valid;
      logic last;
   } ics_ctl_type;

endpackage

[hw/rtl/ics_lane.sv]
// One byte lane: pick a byte, place it in the high or low half of a word, register it.
module ics_lane #(
   parameter int LANES    = ics_pkg::LANES_DEF,
   parameter int LANE_IDX = 0
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [ics_pkg::DATA_W-1:0]  data_bytes,
   input  logic [ics_pkg::CNT_W-1:0]   byte_count,
   input  logic                        phase,
   output logic [ics_pkg::WORD_W-1:0]  lane_word
);
   import ics_pkg::*;

   localparam int SHIFT = BYTE_W * (LANES - 1 - LANE_IDX);
   localparam logic LANE_ODD = 1'(LANE_IDX % 2);

   logic [BYTE_W-1:0] byte_val;
   logic              lane_used;
   logic              odd_pos;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   generate
      if (SHIFT + BYTE_W <= DATA_W) begin : g_in_range
         assign byte_val = data_bytes[SHIFT +: BYTE_W] & BYTE_MASK;
      end else begin : g_out_range
         // byte positions beyond the data word read as zero
         assign byte_val = '0;
      end
   endgenerate

   assign lane_used = (int'(byte_count) > LANE_IDX);
   assign odd_pos   = phase ^ LANE_ODD;

   always_comb begin
      if (!lane_used) begin
         word_in = '0;
      end else if (odd_pos) begin
         word_in = {{(WORD_W-BYTE_W){1'b0}}, byte_val};
      end else begin
         word_in = {byte_val, {(WORD_W-BYTE_W){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign lane_word = word_ff;

endmodule

[hw/rtl/ics_merge.sv]
// Merge stage: add lane words into the folded running sum and emit the checksum.
module ics_merge #(
   parameter int LANES = ics_pkg::LANES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ics_pkg::ics_ctl_type                   ctl,
   input  logic [LANES-1:0][ics_pkg::WORD_W-1:0]  lane_word,
   output logic                                   take,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [ics_pkg::WORD_W-1:0]             rsp_checksum
);
   import ics_pkg::*;

   localparam int SUM_W = WORD_W + $clog2(LANES + 1);

   logic [WORD_W-1:0] sum_ff;
   logic [WORD_W-1:0] sum_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] checksum_ff;
   logic [WORD_W-1:0] checksum_in;

   logic [SUM_W-1:0]  total;
   logic [WORD_W:0]   fold1;
   logic [WORD_W-1:0] fold2;
   logic              out_free;

   always_comb begin
      total = SUM_W'(sum_ff);
      for (int i = 0; i < LANES; i++) begin
         total = total + SUM_W'(lane_word[i]);
      end
   end

   // end-around carry: fold twice, a nonzero sum never folds to zero
   assign fold1 = (WORD_W+1)'(total[WORD_W-1:0]) + (WORD_W+1)'(total[SUM_W-1:WORD_W]);
   assign fold2 = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = ctl.valid && (!ctl.last || out_free);

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      checksum_in  = checksum_ff;
      if (take) begin
         if (ctl.last) begin
            sum_in       = '0;
            rsp_valid_in = 1'b1;
            checksum_in  = ~fold2 & WORD_MASK;
         end else begin
            sum_in = fold2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      checksum_ff <= checksum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = checksum_ff;

endmodule

[hw/rtl/internet_checksum_stream.sv]
// Top level of the streaming Internet checksum: byte lanes feeding a merge stage.
//
// Input channel (req_): one word of up to LANES stream bytes, first byte in the
// top bits, req_byte_count valid bytes counted from the top, req_last on the
// final word of a message. Bytes pair up in network order across word
// boundaries; a byte-position parity carries over from word to word.
// Result channel (rsp_): one rsp_checksum per message, on the word with
// req_last, holding the complement of the folded ones' complement sum.
// Throughput: one word per cycle while req_stall is low. Each lane registers its
// placed byte, then the merge stage adds all lanes into the folded running sum.
// rsp_valid rises once the merge stage takes the last word from the lane
// register into the merge register; a stalled waiting checksum can delay it.
// Reset clears the running sum, the parity and both valid flags.
// While the receiver stalls a waiting checksum, words without req_last keep
// flowing; a following last word holds in the lane stage, and only then does
// req_stall rise.
module internet_checksum_stream #(
   parameter int LANES = ics_pkg::LANES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ics_pkg::DATA_W-1:0]  req_data_bytes,
   input  logic [ics_pkg::CNT_W-1:0]   req_byte_count,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ics_pkg::WORD_W-1:0]  rsp_checksum
);
   import ics_pkg::*;

   localparam logic LANES_ODD = 1'(LANES % 2);

   ics_ctl_type                   ctl_ff;
   ics_ctl_type                   ctl_in;
   logic                          phase_ff;
   logic                          phase_in;
   logic                          take;
   logic                          load;
   logic                          accept;
   logic                          phase_adv;
   logic [LANES-1:0][WORD_W-1:0]  lane_word;

   assign load      = !ctl_ff.valid || take;
   assign req_stall = !load;
   assign accept    = req_valid && load;

   // parity of the saturated byte count
   assign phase_adv = (int'(req_byte_count) > LANES) ? LANES_ODD : req_byte_count[0];

   always_comb begin
      ctl_in   = ctl_ff;
      phase_in = phase_ff;
      if (load) begin
         ctl_in.valid = req_valid;
         ctl_in.last  = req_last;
      end
      if (accept) begin
         phase_in = req_last ? 1'b0 : (phase_ff ^ phase_adv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         ctl_ff   <= ctl_in;
         phase_ff <= phase_in;
      end
   end

   generate
      for (genvar g = 0; g < LANES; g++) begin : g_lane
         ics_lane #(
            .LANES    (LANES),
            .LANE_IDX (g)
         ) u_lane (
            .clock      (clock),
            .load       (accept),
            .data_bytes (req_data_bytes),
            .byte_count (req_byte_count),
            .phase      (phase_ff),
            .lane_word  (lane_word[g])
         );
      end
   endgenerate

   ics_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl_ff),
      .lane_word    (lane_word),
      .take         (take),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_checksum (rsp_checksum)
   );

endmodule
